[rtl/vscs_pkg.sv]
// ----------------------------------------------------------------------------
// vscs_pkg
// shared types and constants of the calibrated sensor scaler
// ----------------------------------------------------------------------------
`default_nettype none

package vscs_pkg;

   localparam int ADC_W      = 12;
   localparam int PERIOD_W   = 24;
   localparam int DIVIDEND_W = 26;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_STEPS  = DIVIDEND_W / 2;
   localparam int STEER_M_W  = 21;

   // item commands
   localparam logic [1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [1:0] CMD_CAP_ZERO   = 2'd1;
   localparam logic [1:0] CMD_CAP_FULL   = 2'd2;
   localparam logic [1:0] CMD_CAP_CENTER = 2'd3;

   localparam logic [DIVIDEND_W-1:0] RPM_NUMERATOR = 26'd60000000;
   localparam logic [22:0]           BRAKE_OFFSET  = 23'd819000;
   localparam logic [DIVISOR_W-1:0]  ADC_FULL      = 32'd4095;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_TPS1,
      OP_TPS2,
      OP_BRAKE,
      OP_LEFT,
      OP_RIGHT,
      OP_STEER
   } op_type;

   typedef struct packed {
      logic   accept;
      logic   start;
      logic   write;
      logic   publish;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/vehicle_sensor_calibrated_scaler.sv]
// ----------------------------------------------------------------------------
// vehicle_sensor_calibrated_scaler
// scales raw throttle, brake, steering and wheel period readings using
// captured calibration points
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            carries
//   req_     in         req_valid/req_stall  command, four adc readings, two periods
//   rsp_     out        rsp_valid/rsp_stall  two throttle %, brake psi, two rpm, angle
//
// a sample beat runs from accept to the next accept through the single shared
// divider, which runs the six conversions one after another at two quotient
// bits per cycle; no new beat is taken until the sample is finished
// calibration beats are taken in the idle state and give no result
// reset (synchronous, active high) clears calibration points and last readings
// a finished result waits in the output register; the next beat is taken
// once the previous result has been moved there
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_sensor_calibrated_scaler #(
   parameter int TEETH_PER_WHEEL = 20,
   parameter int STEER_SPAN_DEG  = 360
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_tps1_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_tps2_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_brake_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_steer_raw,
   input  wire logic [vscs_pkg::PERIOD_W-1:0]  req_left_period,
   input  wire logic [vscs_pkg::PERIOD_W-1:0]  req_right_period,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [6:0]                          rsp_tps1_percent,
   output logic [6:0]                          rsp_tps2_percent,
   output logic [10:0]                         rsp_brake_psi,
   output logic [15:0]                         rsp_left_rpm,
   output logic [15:0]                         rsp_right_rpm,
   output logic [9:0]                          rsp_steer_angle
);
   import vscs_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   // sequencer: one conversion per pass through the divider
   vscs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // datapath: holds the beat, calibration and the output register
   vscs_datapath #(
      .TEETH_PER_WHEEL (TEETH_PER_WHEEL),
      .STEER_SPAN_DEG  (STEER_SPAN_DEG)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_tps1_raw     (req_tps1_raw),
      .req_tps2_raw     (req_tps2_raw),
      .req_brake_raw    (req_brake_raw),
      .req_steer_raw    (req_steer_raw),
      .req_left_period  (req_left_period),
      .req_right_period (req_right_period),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tps1_percent (rsp_tps1_percent),
      .rsp_tps2_percent (rsp_tps2_percent),
      .rsp_brake_psi    (rsp_brake_psi),
      .rsp_left_rpm     (rsp_left_rpm),
      .rsp_right_rpm    (rsp_right_rpm),
      .rsp_steer_angle  (rsp_steer_angle)
   );

endmodule

`default_nettype wire

[rtl/vscs_div.sv]
// ----------------------------------------------------------------------------
// vscs_div
// iterative unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vscs_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [vscs_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire logic [vscs_pkg::DIVISOR_W-1:0]   divisor,
   output logic                                  done,
   output logic [vscs_pkg::DIVIDEND_W-1:0]       quotient
);
   import vscs_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    r1, r2;
   logic [DIVISOR_W-1:0]  r1s, r2s;
   logic                  ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? DIVISOR_W'(r1 - {1'b0, den_ff}) : r1[DIVISOR_W-1:0];
      r2  = {r1s, quo_ff[DIVIDEND_W-2]};
      ge2 = r2 >= {1'b0, den_ff};
      r2s = ge2 ? DIVISOR_W'(r2 - {1'b0, den_ff}) : r2[DIVISOR_W-1:0];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 4'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-3:0], ge1, ge2};
         rem_in = r2s;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/vscs_ctrl.sv]
// ----------------------------------------------------------------------------
// vscs_ctrl
// sequencer: walks the six conversions of a sample through the divider
// ----------------------------------------------------------------------------
`default_nettype none

module vscs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [1:0]              req_cmd,
   output logic                         req_stall,
   input  wire vscs_pkg::dp_status_type status,
   output vscs_pkg::ctrl_cmd_type       ctrl
);
   import vscs_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            op_in = OP_TPS1;
            if (req_valid && req_cmd == CMD_SAMPLE) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (op_ff == OP_STEER) begin
               state_in = ST_FINISH;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.accept  = 1'b0;
      ctrl.start   = 1'b0;
      ctrl.write   = 1'b0;
      ctrl.publish = 1'b0;
      ctrl.op      = op_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.accept = req_valid;
         end
         ST_LOAD:   ctrl.start   = 1'b1;
         ST_DIV:    ;
         ST_WRITE:  ctrl.write   = 1'b1;
         ST_FINISH: ctrl.publish = status.out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_TPS1;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

`default_nettype wire

[rtl/vscs_datapath.sv]
// ----------------------------------------------------------------------------
// vscs_datapath
// input capture, calibration points, operand setup, result fixup, output beat
// ----------------------------------------------------------------------------
`default_nettype none

module vscs_datapath #(
   parameter int TEETH_PER_WHEEL = 20,
   parameter int STEER_SPAN_DEG  = 360
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire vscs_pkg::ctrl_cmd_type         ctrl,
   output vscs_pkg::dp_status_type             status,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_tps1_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_tps2_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_brake_raw,
   input  wire logic [vscs_pkg::ADC_W-1:0]     req_steer_raw,
   input  wire logic [vscs_pkg::PERIOD_W-1:0]  req_left_period,
   input  wire logic [vscs_pkg::PERIOD_W-1:0]  req_right_period,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [6:0]                          rsp_tps1_percent,
   output logic [6:0]                          rsp_tps2_percent,
   output logic [10:0]                         rsp_brake_psi,
   output logic [15:0]                         rsp_left_rpm,
   output logic [15:0]                         rsp_right_rpm,
   output logic [9:0]                          rsp_steer_angle
);
   import vscs_pkg::*;

   // held sample
   logic [ADC_W-1:0]    t1_ff, t2_ff, br_ff, st_ff;
   logic [PERIOD_W-1:0] lp_ff, rp_ff;
   // calibration points and last raw readings
   logic [ADC_W-1:0] z1_ff, f1_ff, z2_ff, f2_ff, bz_ff, sc_ff;
   logic [ADC_W-1:0] last_ff [4];

   // staged results
   logic [6:0]  p1_ff, p2_ff;
   logic [10:0] psi_ff;
   logic [15:0] lrpm_ff, rrpm_ff;
   logic [9:0]  ang_ff;
   // output beat
   logic        out_valid_ff, out_valid_in;
   logic [6:0]  o_p1_ff, o_p2_ff;
   logic [10:0] o_psi_ff;
   logic [15:0] o_lrpm_ff, o_rrpm_ff;
   logic [9:0]  o_ang_ff;

   logic [ADC_W-1:0]      span1, span2, num1, num2, steer_mag;
   logic [ADC_W:0]        steer_diff;
   logic                  steer_neg;
   logic [22:0]           brake_prod;
   logic [STEER_M_W-1:0]  steer_m;
   logic [DIVISOR_W-1:0]  lden, rden;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVISOR_W-1:0]  divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] q;
   logic signed [10:0]    steer_sum;

   always_comb begin
      span1      = z1_ff - f1_ff;
      num1       = z1_ff - t1_ff;
      span2      = f2_ff - z2_ff;
      num2       = t2_ff - z2_ff;
      brake_prod = 23'(br_ff) * 23'd2000;
      steer_diff = {1'b0, st_ff} - {1'b0, sc_ff};
      steer_neg  = steer_diff[ADC_W];
      steer_mag  = steer_neg ? ADC_W'(-steer_diff) : steer_diff[ADC_W-1:0];
      steer_m    = STEER_M_W'(steer_mag) * STEER_M_W'(STEER_SPAN_DEG);
      lden       = DIVISOR_W'(lp_ff) * DIVISOR_W'(TEETH_PER_WHEEL);
      rden       = DIVISOR_W'(rp_ff) * DIVISOR_W'(TEETH_PER_WHEEL);
   end

   always_comb begin
      dividend = '0;
      divisor  = ADC_FULL;
      unique case (ctrl.op)
         OP_TPS1: begin
            dividend = DIVIDEND_W'(num1) * DIVIDEND_W'(100);
            divisor  = DIVISOR_W'(span1);
         end
         OP_TPS2: begin
            dividend = DIVIDEND_W'(num2) * DIVIDEND_W'(100);
            divisor  = DIVISOR_W'(span2);
         end
         OP_BRAKE: dividend = DIVIDEND_W'(brake_prod - BRAKE_OFFSET);
         OP_LEFT: begin
            dividend = RPM_NUMERATOR;
            divisor  = lden;
         end
         OP_RIGHT: begin
            dividend = RPM_NUMERATOR;
            divisor  = rden;
         end
         OP_STEER: dividend = DIVIDEND_W'(steer_m);
         default: ;
      endcase
   end

   vscs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (q)
   );

   assign steer_sum = steer_neg ? 11'sd180 - $signed({2'b00, q[8:0]})
                                : 11'sd180 + $signed({2'b00, q[8:0]});

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         t1_ff <= req_tps1_raw;
         t2_ff <= req_tps2_raw;
         br_ff <= req_brake_raw;
         st_ff <= req_steer_raw;
         lp_ff <= req_left_period;
         rp_ff <= req_right_period;
      end
      if (ctrl.write) begin
         unique case (ctrl.op)
            OP_TPS1: begin
               if (t1_ff > z1_ff)                     p1_ff <= 7'd0;
               else if (t1_ff < f1_ff)                p1_ff <= 7'd100;
               else if (span1 == '0)                  p1_ff <= 7'd0;
               else if (q > DIVIDEND_W'(100))         p1_ff <= 7'd100;
               else                                   p1_ff <= q[6:0];
            end
            OP_TPS2: begin
               if (t2_ff < z2_ff)                     p2_ff <= 7'd0;
               else if (t2_ff > f2_ff)                p2_ff <= 7'd100;
               else if (span2 == '0)                  p2_ff <= 7'd0;
               else if (q > DIVIDEND_W'(100))         p2_ff <= 7'd100;
               else                                   p2_ff <= q[6:0];
            end
            OP_BRAKE: begin
               if (br_ff < bz_ff || brake_prod < BRAKE_OFFSET) psi_ff <= 11'd0;
               else                                            psi_ff <= q[10:0];
            end
            OP_LEFT: begin
               if (lp_ff == '0)                         lrpm_ff <= 16'd0;
               else if (q >= DIVIDEND_W'(65535))        lrpm_ff <= 16'hFFFF;
               else                                     lrpm_ff <= q[15:0];
            end
            OP_RIGHT: begin
               if (rp_ff == '0)                         rrpm_ff <= 16'd0;
               else if (q >= DIVIDEND_W'(65535))        rrpm_ff <= 16'hFFFF;
               else                                     rrpm_ff <= q[15:0];
            end
            OP_STEER: begin
               if (steer_sum[10]) ang_ff <= 10'd0;
               else               ang_ff <= steer_sum[9:0];
            end
            default: ;
         endcase
      end
      if (ctrl.publish) begin
         o_p1_ff   <= p1_ff;
         o_p2_ff   <= p2_ff;
         o_psi_ff  <= psi_ff;
         o_lrpm_ff <= lrpm_ff;
         o_rrpm_ff <= rrpm_ff;
         o_ang_ff  <= ang_ff;
      end
   end

   // calibration and last raw readings
   always_ff @(posedge clock) begin
      if (reset) begin
         z1_ff <= '0;
         f1_ff <= '0;
         z2_ff <= '0;
         f2_ff <= '0;
         bz_ff <= '0;
         sc_ff <= '0;
         for (int i = 0; i < 4; i++) last_ff[i] <= '0;
      end else if (ctrl.accept) begin
         case (req_cmd)
            CMD_SAMPLE: begin
               last_ff[0] <= req_tps1_raw;
               last_ff[1] <= req_tps2_raw;
               last_ff[2] <= req_brake_raw;
               last_ff[3] <= req_steer_raw;
            end
            CMD_CAP_ZERO: begin
               z1_ff <= last_ff[0];
               z2_ff <= last_ff[1];
               bz_ff <= last_ff[2];
            end
            CMD_CAP_FULL: begin
               f1_ff <= last_ff[0];
               f2_ff <= last_ff[1];
            end
            CMD_CAP_CENTER: sc_ff <= last_ff[3];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_valid_in = ctrl.publish ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   assign status.div_done = div_done;
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid        = out_valid_ff;
   assign rsp_tps1_percent = o_p1_ff;
   assign rsp_tps2_percent = o_p2_ff;
   assign rsp_brake_psi    = o_psi_ff;
   assign rsp_left_rpm     = o_lrpm_ff;
   assign rsp_right_rpm    = o_rrpm_ff;
   assign rsp_steer_angle  = o_ang_ff;

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for vehicle_sensor_calibrated_scaler
// drives sample and calibration beats with random gaps and output stalls,
// predicts every result from a software model of the scaler, checks in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected reading sets and the scaler's calibration state
class scaler_scoreboard;
   logic [11:0] t1_zero, t1_full, t2_zero, t2_full, br_zero, st_center;
   logic [11:0] last_t1, last_t2, last_br, last_st;
   logic [6:0]  exp_p1[$];
   logic [6:0]  exp_p2[$];
   logic [10:0] exp_psi[$];
   logic [15:0] exp_lrpm[$];
   logic [15:0] exp_rrpm[$];
   logic [9:0]  exp_ang[$];
   int          errors;

   function new();
      t1_zero = '0; t1_full = '0; t2_zero = '0; t2_full = '0; br_zero = '0; st_center = '0;
      last_t1 = '0; last_t2 = '0; last_br = '0; last_st = '0;
      errors = 0;
   endfunction

   function int pending();
      return exp_p1.size();
   endfunction

   function logic [15:0] rpm_of(logic [23:0] period);
      longint q;
      if (period == 0) return 16'd0;
      q = 64'd60000000 / (longint'(period) * 20);
      return (q >= 65535) ? 16'hffff : q[15:0];
   endfunction

   function void note_beat(logic [1:0] cmd, logic [11:0] t1, logic [11:0] t2,
                           logic [11:0] br, logic [11:0] st,
                           logic [23:0] lp, logic [23:0] rp);
      longint p1, p2, v, a;
      case (cmd)
         vscs_pkg::CMD_CAP_ZERO: begin
            t1_zero = last_t1; t2_zero = last_t2; br_zero = last_br;
         end
         vscs_pkg::CMD_CAP_FULL: begin
            t1_full = last_t1; t2_full = last_t2;
         end
         vscs_pkg::CMD_CAP_CENTER: st_center = last_st;
         default: begin
            last_t1 = t1; last_t2 = t2; last_br = br; last_st = st;
            // throttle one falls as it opens
            if (t1 > t1_zero) p1 = 0;
            else if (t1 < t1_full) p1 = 100;
            else if (t1_zero == t1_full) p1 = 0;
            else p1 = (longint'(t1_zero - t1) * 100) / longint'(t1_zero - t1_full);
            if (t2 < t2_zero) p2 = 0;
            else if (t2 > t2_full) p2 = 100;
            else if (t2_zero == t2_full) p2 = 0;
            else p2 = (longint'(t2 - t2_zero) * 100) / longint'(t2_full - t2_zero);
            if (p1 > 100) p1 = 100;
            if (p2 > 100) p2 = 100;
            if (br < br_zero) v = 0;
            else begin
               v = (longint'(br) * 2000 - 819000) / 4095;
               if (v < 0) v = 0;
            end
            // signed division truncates toward zero as required
            a = ((longint'(st) - longint'(st_center)) * 360) / 4095 + 180;
            if (a < 0) a = 0;
            exp_p1.push_back(p1[6:0]);
            exp_p2.push_back(p2[6:0]);
            exp_psi.push_back(v[10:0]);
            exp_lrpm.push_back(rpm_of(lp));
            exp_rrpm.push_back(rpm_of(rp));
            exp_ang.push_back(a[9:0]);
         end
      endcase
   endfunction

   function void check_field(string name, longint e, longint g);
      if (e != g) begin
         errors++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, g);
      end
   endfunction

   function void check_result(logic [6:0] p1, logic [6:0] p2, logic [10:0] psi,
                              logic [15:0] lr, logic [15:0] rr, logic [9:0] ang);
      if (exp_p1.size() == 0) begin
         errors++;
         $display("%0t unexpected result beat, expected none actual %0d", $time, p1);
         return;
      end
      check_field("tps1_percent", exp_p1.pop_front(), p1);
      check_field("tps2_percent", exp_p2.pop_front(), p2);
      check_field("brake_psi", exp_psi.pop_front(), psi);
      check_field("left_rpm", exp_lrpm.pop_front(), lr);
      check_field("right_rpm", exp_rrpm.pop_front(), rr);
      check_field("steer_angle", exp_ang.pop_front(), ang);
   endfunction
endclass

module testbench;
   import vscs_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_SAMPLE;
   logic [11:0] req_tps1_raw = '0, req_tps2_raw = '0, req_brake_raw = '0, req_steer_raw = '0;
   logic [23:0] req_left_period = '0, req_right_period = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [6:0]  rsp_tps1_percent, rsp_tps2_percent;
   logic [10:0] rsp_brake_psi;
   logic [15:0] rsp_left_rpm, rsp_right_rpm;
   logic [9:0]  rsp_steer_angle;

   scaler_scoreboard sb = new();
   bit  quiet_phase = 0;   // no idling on either side near the end
   bit  hold_off    = 0;   // receiver holds off for a long stretch
   int  items_sent  = 0;

   vehicle_sensor_calibrated_scaler uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8ns * 3_000_000);
      $display("tb: failure");
      $finish;
   end

   // result side: random stall bursts, a long hold-off when asked
   initial begin
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
            rsp_stall <= 1;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   // results are sampled at the edge where the beat is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_tps1_percent, rsp_tps2_percent, rsp_brake_psi,
                         rsp_left_rpm, rsp_right_rpm, rsp_steer_angle);
   end

   // offer one beat, hold it until taken, then maybe idle
   task automatic send_beat(logic [1:0] cmd, logic [11:0] t1, logic [11:0] t2,
                            logic [11:0] br, logic [11:0] st,
                            logic [23:0] lp, logic [23:0] rp);
      int gap;
      req_valid <= 1;
      req_cmd <= cmd;
      req_tps1_raw <= t1; req_tps2_raw <= t2;
      req_brake_raw <= br; req_steer_raw <= st;
      req_left_period <= lp; req_right_period <= rp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(cmd, t1, t2, br, st, lp, rp);
      items_sent++;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_sample(logic [11:0] t1, logic [11:0] t2, logic [11:0] br,
                              logic [11:0] st, logic [23:0] lp, logic [23:0] rp);
      send_beat(CMD_SAMPLE, t1, t2, br, st, lp, rp);
   endtask

   // capture with random junk in the ignored fields
   task automatic send_capture(logic [1:0] cmd);
      send_beat(cmd, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                24'($urandom), 24'($urandom));
   endtask

   function automatic logic [23:0] rand_period();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'($urandom_range(1, 60));
         2: return 24'(24'hffffff - $urandom_range(0, 3));
         3: return 24'($urandom_range(40, 5000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] near(logic [11:0] base);
      int v;
      v = int'(base) + $urandom_range(0, 40) - 20;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   initial begin
      int kind;
      logic [11:0] z1, f1, z2, f2;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: captures before any sample take zeros
      send_capture(CMD_CAP_ZERO);
      send_capture(CMD_CAP_FULL);
      send_capture(CMD_CAP_CENTER);
      // zero span, extremes of every field
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(12'hfff, 12'hfff, 12'hfff, 12'hfff, 24'hffffff, 24'hffffff);
      send_sample(12'h000, 12'hfff, 409, 0, 1, 2);
      send_sample(12'hfff, 12'h000, 410, 12'hfff, 49, 50);
      // calibrate a real range: zero points, then full points, then center
      send_sample(3800, 300, 500, 2048, 3000, 0);
      send_capture(CMD_CAP_ZERO);
      send_sample(400, 3700, 100, 2048, 12345, 999);
      send_capture(CMD_CAP_FULL);
      send_capture(CMD_CAP_CENTER);
      send_sample(3800, 300, 499, 2048, 100, 100);
      send_sample(400, 3700, 500, 0, 7, 8);
      send_sample(2100, 2000, 4095, 4095, 60, 61);
      send_sample(4095, 0, 0, 1, 0, 24'h800000);
      send_sample(0, 4095, 1000, 2047, 24'h555555, 24'haaaaaa);
      // inverted calibration: full above zero on throttle one
      send_sample(100, 4000, 0, 4000, 10, 10);
      send_capture(CMD_CAP_ZERO);
      send_sample(4000, 100, 0, 12, 10, 10);
      send_capture(CMD_CAP_FULL);
      send_sample(2000, 2000, 4095, 300, 10, 10);
      send_sample(50, 4050, 4095, 3000, 10, 10);

      // pause until drained
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);

      // long receiver hold-off while beats keep coming
      hold_off = 1;
      repeat (12) send_sample(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                              rand_period(), rand_period());

      // random part: a mix of captures, calibrate-then-sample sequences and samples
      while (items_sent < 750) begin
         if (items_sent > 650) quiet_phase = 1;
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_capture(2'($urandom_range(1, 3)));
         end else if (kind == 1) begin
            z1 = 12'($urandom_range(2500, 4095)); f1 = 12'($urandom_range(0, 1500));
            z2 = 12'($urandom_range(0, 1500));    f2 = 12'($urandom_range(2500, 4095));
            if ($urandom_range(0, 5) == 0) begin f1 = z1; f2 = z2; end
            send_sample(z1, z2, 12'($urandom), 12'($urandom), rand_period(), rand_period());
            send_capture(CMD_CAP_ZERO);
            send_sample(f1, f2, 12'($urandom), 12'($urandom), rand_period(), rand_period());
            send_capture(CMD_CAP_FULL);
            if ($urandom_range(0, 1)) send_capture(CMD_CAP_CENTER);
         end else if (kind < 5) begin
            send_sample(near(sb.t1_zero), near(sb.t2_full), near(sb.br_zero),
                        near(sb.st_center), rand_period(), rand_period());
         end else begin
            send_sample(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                        rand_period(), rand_period());
         end
      end
      req_valid <= 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/vscs_pkg.sv
rtl/vscs_div.sv
rtl/vscs_ctrl.sv
rtl/vscs_datapath.sv
rtl/vehicle_sensor_calibrated_scaler.sv
sim/testbench.sv
